FILE: rtl/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg - shared types and constants of the descriptor page splitter
// Widths, limits and the structs passed between the splitter's units.
// ----------------------------------------------------------------------------
package dps_pkg;

   // byte counts, lengths and running totals
   localparam int CNT_W     = 17;
   localparam int ADDR_W    = 32;
   localparam int PRD_CNT_W = 13;
   localparam int SLOT_IDX_W = 5;
   localparam int NRES_W    = 5;

   localparam logic [CNT_W-1:0]  LEN_CAP   = 17'h10000;
   localparam logic [CNT_W-1:0]  BIG_LIMIT = 17'h10000;
   localparam logic [CNT_W-1:0]  TOTAL_SAT = 17'h1FFFF;

   // most results one request may produce
   localparam logic [NRES_W-1:0] RES_MAX   = 5'd17;

   // result of the shared page splitting step
   typedef struct packed {
      logic [CNT_W-1:0] piece;
      logic [CNT_W-1:0] rem_next;
      logic             last_piece;
   } piece_type;

   // table bookkeeping seen by the current piece
   typedef struct packed {
      logic                  valid;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [CNT_W-1:0]      total;
      logic                  too_big;
   } slot_status_type;

endpackage

FILE: rtl/dps_piece_unit.sv
// ----------------------------------------------------------------------------
// dps_piece_unit - shared page splitting step
// Cuts the remaining segment at the next page boundary: one subtract for
// the room left in the page, one compare for the piece, one subtract for
// what is left after it.
// ----------------------------------------------------------------------------
module dps_piece_unit #(
   parameter int PAGE_SIZE = 4096
) (
   input  logic [dps_pkg::ADDR_W-1:0] cur_addr,
   input  logic [dps_pkg::CNT_W-1:0]  rem,
   output dps_pkg::piece_type         result
);
   import dps_pkg::*;

   // page size is a power of two
   localparam int PAGE_LOG = $clog2(PAGE_SIZE);

   logic [PAGE_LOG:0]   room_raw;
   logic [CNT_W-1:0]    room;
   logic [CNT_W-1:0]    piece;

   assign room_raw = (PAGE_LOG+1)'(PAGE_SIZE) - {1'b0, cur_addr[PAGE_LOG-1:0]};
   assign room     = CNT_W'(room_raw);
   assign piece    = (room < rem) ? room : rem;

   assign result.piece      = piece;
   assign result.rem_next   = rem - piece;
   assign result.last_piece = (rem == piece);

endmodule

FILE: rtl/dps_table_state.sv
// ----------------------------------------------------------------------------
// dps_table_state - slot counter and running byte total
// Grants a slot while the table has room, saturates the total, and clears
// both after the final piece of the last segment.
// ----------------------------------------------------------------------------
module dps_table_state #(
   parameter int MAX_SLOTS = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      clear,
   input  logic [dps_pkg::CNT_W-1:0] piece,
   output dps_pkg::slot_status_type  status
);
   import dps_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W:0]    sum;
   logic [CNT_W-1:0]  total_next;
   logic              grant;

   assign grant      = (slot_ff < SLOT_W'(MAX_SLOTS));
   assign sum        = {1'b0, total_ff} + {1'b0, piece};
   // saturate the total
   assign total_next = grant ? (sum[CNT_W] ? TOTAL_SAT : sum[CNT_W-1:0]) : total_ff;

   assign status.valid      = grant;
   assign status.slot_index = grant ? SLOT_IDX_W'(slot_ff) : '0;
   assign status.total      = total_next;
   assign status.too_big    = (total_next > BIG_LIMIT);

   always_comb begin
      slot_in  = slot_ff;
      total_in = total_ff;
      if (step) begin
         if (clear) begin
            slot_in  = '0;
            total_in = '0;
         end else begin
            if (grant) begin
               slot_in = slot_ff + SLOT_W'(1);
            end
            total_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         total_ff <= '0;
      end else begin
         slot_ff  <= slot_in;
         total_ff <= total_in;
      end
   end

endmodule

FILE: rtl/dma_descriptor_page_splitter.sv
// ----------------------------------------------------------------------------
// dma_descriptor_page_splitter - physical region descriptor table builder
// Splits each scatter-gather segment at page boundaries and emits one
// descriptor result per piece, with slot, running total and table flags.
//
//   channel  ports                 direction  contents
//   -------  --------------------  ---------  ------------------------------
//   req      req_valid/req_stall   in         segment: addr, len, last mark
//   rsp      rsp_valid/rsp_stall   out        one descriptor per page piece
//
// Flow: a request is loaded in ST_IDLE and then split into pieces (1 to 17
//   pieces), one piece per cycle through the shared page splitting unit
//   while the result register is free to take it.
// req_stall stays high while a segment is being split; the next request is
// taken at the edge after its last piece is loaded into the result register.
// rsp_stall holds the result register and the splitter waits with it.
// Reset (synchronous) clears the sequencer, slot counter and byte total.
// ----------------------------------------------------------------------------
module dma_descriptor_page_splitter #(
   parameter int MAX_SLOTS  = 17,
   parameter int PAGE_SIZE  = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dps_pkg::ADDR_W-1:0]    req_seg_addr,
   input  logic [dps_pkg::CNT_W-1:0]     req_seg_len,
   input  logic                          req_last_seg,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_entry_valid,
   output logic [dps_pkg::ADDR_W-1:0]    rsp_prd_addr,
   output logic [dps_pkg::PRD_CNT_W-1:0] rsp_prd_count,
   output logic                          rsp_end_of_table,
   output logic [dps_pkg::SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [dps_pkg::CNT_W-1:0]     rsp_byte_total,
   output logic                          rsp_slot_overflow,
   output logic                          rsp_too_big,
   output logic                          rsp_run_last
);
   import dps_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // sequencer state
   logic              state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              last_ff, last_in;
   logic [NRES_W-1:0] n_ff, n_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  entry_valid_ff;
   logic [ADDR_W-1:0]     prd_addr_ff;
   logic [PRD_CNT_W-1:0]  prd_count_ff;
   logic                  eot_ff;
   logic [SLOT_IDX_W-1:0] slot_index_ff;
   logic [CNT_W-1:0]      byte_total_ff;
   logic                  overflow_ff;
   logic                  too_big_ff;
   logic                  run_last_ff;

   piece_type       pc;
   slot_status_type st;
   logic            accept;
   logic            out_free;
   logic            emit;
   logic            stop;

   dps_piece_unit #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_piece (
      .cur_addr (addr_ff),
      .rem      (rem_ff),
      .result   (pc)
   );

   dps_table_state #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .step   (emit),
      .clear  (stop && last_ff),
      .piece  (pc.piece),
      .status (st)
   );

   assign req_stall = (state_ff == ST_RUN);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == ST_RUN) && out_free;
   // stop at the end of the segment or at the per-request result limit
   assign stop      = pc.last_piece || (n_ff == RES_MAX - NRES_W'(1));

   // sequencer: load a segment, then advance one piece per free result slot
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      last_in  = last_ff;
      n_in     = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               addr_in  = req_seg_addr;
               rem_in   = (req_seg_len > LEN_CAP) ? LEN_CAP : req_seg_len;
               last_in  = req_last_seg;
               n_in     = '0;
            end
         end
         ST_RUN: begin
            if (emit) begin
               addr_in = addr_ff + ADDR_W'(pc.piece);
               rem_in  = pc.rem_next;
               n_in    = n_ff + NRES_W'(1);
               if (stop) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      last_ff <= last_in;
      n_ff    <= n_in;
   end

   // result register: drop the result valid when taken, load a new piece on emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         entry_valid_ff <= st.valid;
         prd_addr_ff    <= st.valid ? addr_ff : '0;
         prd_count_ff   <= st.valid ? pc.piece[PRD_CNT_W-1:0] : '0;
         eot_ff         <= last_ff && stop;
         slot_index_ff  <= st.slot_index;
         byte_total_ff  <= st.total;
         overflow_ff    <= !st.valid;
         too_big_ff     <= st.too_big;
         run_last_ff    <= stop;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_valid   = entry_valid_ff;
   assign rsp_prd_addr      = prd_addr_ff;
   assign rsp_prd_count     = prd_count_ff;
   assign rsp_end_of_table  = eot_ff;
   assign rsp_slot_index    = slot_index_ff;
   assign rsp_byte_total    = byte_total_ff;
   assign rsp_slot_overflow = overflow_ff;
   assign rsp_too_big       = too_big_ff;
   assign rsp_run_last      = run_last_ff;

endmodule
